// ----- hdl/itoa_pkg.sv -----
// ----------------------------------------------------------------------------
// itoa_pkg: shared definitions for the radix text converter
// Holds the default sizes, the radix limits, the character codes and the
// controller state type used by integer_to_radix_ascii.
// ----------------------------------------------------------------------------
package itoa_pkg;

	// Default sizes handed to the top level parameters.
	localparam int VALUE_BITS_DEF = 32;
	localparam int MAX_CHARS_DEF  = 33;

	// Radix register width, reset value and the range that converts.
	localparam int          RADIX_BITS  = 6;
	localparam logic [5:0]  RADIX_RESET = 6'd10;
	localparam logic [5:0]  RADIX_MIN   = 6'd2;
	localparam logic [5:0]  RADIX_MAX   = 6'd36;

	// Character codes.
	localparam int         CHAR_BITS  = 8;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_A     = 8'h61;
	localparam logic [7:0] CHAR_NONE  = 8'h00;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_EMPTY,
		ST_SIGN,
		ST_READ,
		ST_EMIT
	} itoa_state_t;

	// Map a digit value 0..35 onto '0'-'9' and 'a'-'z'.
	function automatic logic [7:0] digit_char(input logic [5:0] d);
		logic [7:0] code;
		if (d < 6'd10) begin
			code = CHAR_ZERO + {2'b00, d};
		end else begin
			code = CHAR_A + {2'b00, d} - 8'd10;
		end
		return code;
	endfunction

endpackage

// ----- hdl/integer_to_radix_ascii.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_ascii: signed integer to ASCII text in radix 2..36
// Converts one integer per input beat into a string of output beats, one
// character each, most significant character first.
// ----------------------------------------------------------------------------
// One input beat yields the text of its value: a '-' for a negative value,
// then the digits ('0'-'9', 'a'-'z'), with is_last marking the final
// character. A radix outside 2..36 yields a single beat with is_empty and
// is_last set. Digits are produced by a one-bit-per-cycle restoring divider;
// the digits land in a small memory and are read back in reverse, each
// character passing a read state and an emit state, and the output may hold
// back any beat. The radix register may only be written while the block is
// idle and is read directly during conversion.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii #(
	parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF,
	parameter int MAX_CHARS  = itoa_pkg::MAX_CHARS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write channel.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [itoa_pkg::RADIX_BITS-1:0]  radix,
	// Input channel.
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [VALUE_BITS-1:0]     value,
	// Output channel.
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [itoa_pkg::CHAR_BITS-1:0]   char_code,
	output logic                             is_last,
	output logic                             is_empty
);

	localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
	localparam int CW = $clog2(MAX_CHARS + 1);
	localparam int BW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam logic [BW-1:0] BIT_LAST  = BW'(VALUE_BITS - 1);
	localparam logic [CW-1:0] CNT_LIMIT = CW'(MAX_CHARS);

	itoa_pkg::itoa_state_t state_q, state_d;

	logic [itoa_pkg::RADIX_BITS-1:0] radix_q;
	logic [VALUE_BITS-1:0]           quo_q;
	logic [5:0]                      rem_q;
	logic [BW-1:0]                   bit_q;
	logic [CW-1:0]                   cnt_q;
	logic                            neg_q;
	logic [5:0]                      rd_data_q;
	logic [5:0]                      digit_mem [MAX_CHARS];

	logic                            out_valid_q;
	logic [itoa_pkg::CHAR_BITS-1:0]  char_code_q;
	logic                            is_last_q;
	logic                            is_empty_q;

	logic                            in_fire;
	logic                            radix_ok;
	logic [VALUE_BITS-1:0]           magnitude;
	logic [6:0]                      rem_shift;
	logic                            quo_bit;
	logic [5:0]                      rem_new;
	logic [VALUE_BITS-1:0]           quo_new;
	logic [CW-1:0]                   cnt_inc;
	logic                            digit_end;
	logic                            div_done;
	logic                            out_free;

	// Control outputs of the state machine.
	logic                            out_load;
	logic [itoa_pkg::CHAR_BITS-1:0]  out_char_d;
	logic                            out_last_d;
	logic                            out_empty_d;
	logic                            mem_re;

	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign radix_ok  = (radix_q >= itoa_pkg::RADIX_MIN) && (radix_q <= itoa_pkg::RADIX_MAX);
	assign out_free  = !out_valid_q || out_ready;

	// Magnitude of the input; the most negative value wraps to 2^(N-1) exactly.
	assign magnitude = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

	// One restoring division step: shift in the next dividend bit and subtract.
	assign rem_shift = {rem_q, quo_q[VALUE_BITS-1]};
	assign quo_bit   = rem_shift >= {1'b0, radix_q};
	assign rem_new   = quo_bit ? 6'(rem_shift - {1'b0, radix_q}) : rem_shift[5:0];
	assign quo_new   = {quo_q[VALUE_BITS-2:0], quo_bit};
	assign cnt_inc   = cnt_q + 1'b1;
	assign digit_end = (bit_q == BIT_LAST);
	assign div_done  = digit_end && ((quo_new == '0) || (cnt_inc == CNT_LIMIT));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			itoa_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = radix_ok ? itoa_pkg::ST_DIVIDE : itoa_pkg::ST_EMPTY;
				end
			end
			itoa_pkg::ST_DIVIDE: begin
				if (div_done) begin
					state_d = (neg_q && (cnt_inc != CNT_LIMIT)) ?
						itoa_pkg::ST_SIGN : itoa_pkg::ST_READ;
				end
			end
			itoa_pkg::ST_EMPTY: begin
				if (out_free) begin
					state_d = itoa_pkg::ST_IDLE;
				end
			end
			itoa_pkg::ST_SIGN: begin
				if (out_free) begin
					state_d = itoa_pkg::ST_READ;
				end
			end
			itoa_pkg::ST_READ: begin
				state_d = itoa_pkg::ST_EMIT;
			end
			itoa_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = (cnt_q == '0) ? itoa_pkg::ST_IDLE : itoa_pkg::ST_READ;
				end
			end
			default: begin
				state_d = itoa_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs of the state machine.
	always_comb begin
		in_ready    = 1'b0;
		out_load    = 1'b0;
		out_char_d  = itoa_pkg::CHAR_NONE;
		out_last_d  = 1'b0;
		out_empty_d = 1'b0;
		mem_re      = 1'b0;
		case (state_q)
			itoa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			itoa_pkg::ST_EMPTY: begin
				out_load    = out_free;
				out_last_d  = 1'b1;
				out_empty_d = 1'b1;
			end
			itoa_pkg::ST_SIGN: begin
				out_load   = out_free;
				out_char_d = itoa_pkg::CHAR_MINUS;
			end
			itoa_pkg::ST_READ: begin
				mem_re = 1'b1;
			end
			itoa_pkg::ST_EMIT: begin
				out_load   = out_free;
				out_char_d = itoa_pkg::digit_char(rd_data_q);
				out_last_d = (cnt_q == '0);
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// State register and radix register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itoa_pkg::ST_IDLE;
			radix_q <= itoa_pkg::RADIX_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				radix_q <= radix;
			end
		end
	end

	// Divider datapath, digit count and sign.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q <= '0;
			rem_q <= '0;
			bit_q <= '0;
			cnt_q <= '0;
			neg_q <= 1'b0;
		end else if (in_fire && radix_ok) begin
			quo_q <= magnitude;
			rem_q <= '0;
			bit_q <= '0;
			cnt_q <= '0;
			neg_q <= value[VALUE_BITS-1];
		end else if (state_q == itoa_pkg::ST_DIVIDE) begin
			quo_q <= quo_new;
			if (digit_end) begin
				rem_q <= '0;
				bit_q <= '0;
				cnt_q <= cnt_inc;
			end else begin
				rem_q <= rem_new;
				bit_q <= bit_q + 1'b1;
			end
		end else if (mem_re) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Digit memory: written least significant digit first, read back in reverse.
	always_ff @(posedge clk) begin
		if ((state_q == itoa_pkg::ST_DIVIDE) && digit_end) begin
			digit_mem[cnt_q[AW-1:0]] <= rem_new;
		end
		if (mem_re) begin
			rd_data_q <= digit_mem[AW'(cnt_q - 1'b1)];
		end
	end

	// Output register: holds a beat until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			char_code_q <= out_char_d;
			is_last_q   <= out_last_d;
			is_empty_q  <= out_empty_d;
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_code_q;
	assign is_last   = is_last_q;
	assign is_empty  = is_empty_q;

	// Digit writes stay inside the memory.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == itoa_pkg::ST_DIVIDE) |-> (cnt_q < CNT_LIMIT))
		else $error("digit count out of range during division");

	// The partial remainder never reaches the radix.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == itoa_pkg::ST_DIVIDE) |-> (rem_q < radix_q))
		else $error("partial remainder not below radix");

	// The final digit closes the text and frees the block.
	a_last_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == itoa_pkg::ST_EMIT && out_free && cnt_q == '0) |=>
		(state_q == itoa_pkg::ST_IDLE && out_valid_q && is_last_q))
		else $error("last digit did not end the text");

	// An empty result is always the last beat of its item.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_empty_q) |-> is_last_q)
		else $error("empty beat without last flag");

endmodule
